// ===== hdl/cbrb_pkg.sv =====
// Shared types and constants for the cell buffer with rectangle blend.
// Depends on nothing; every other file of the block but cbrb_ram imports it.
package cbrb_pkg;

    // Field widths of the input and result beats
    localparam int OP_W      = 2;
    localparam int COORD_W   = 8;
    localparam int COLOR_W   = 32;
    localparam int GLYPH_W   = 21;
    localparam int CHAN_W    = 8;

    // Configuration port
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 2;

    // Linear cell index: (pos_y + row) * stride + pos_x + col fits 18 bits
    localparam int IDX_W     = 18;

    localparam int CELL_CAPACITY_DEFAULT = 4096;
    localparam int QUEUE_DEPTH           = 2;

    // Operation codes
    localparam logic [OP_W-1:0] OP_DRAW = 2'd0;
    localparam logic [OP_W-1:0] OP_PUT  = 2'd1;
    localparam logic [OP_W-1:0] OP_READ = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 9'd80;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 9'd25;

    localparam logic [GLYPH_W-1:0] SPACE_GLYPH  = 21'd32;
    localparam logic [CHAN_W-1:0]  ALPHA_OPAQUE = 8'hFF;

    // Classified command handed from front to back
    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [IDX_W-1:0]   base;
        logic [COORD_W-1:0] rect_w;
        logic [COORD_W-1:0] rect_h;
        logic [COLOR_W-1:0] color;
        logic [GLYPH_W-1:0] glyph;
    } cmd_t;

    // Grid geometry seen by the back end
    typedef struct packed {
        logic [CFG_W-1:0] stride;
        logic [IDX_W-1:0] limit;
    } grid_t;

    // Back end status toward the front
    typedef struct packed {
        logic accepting;
        logic busy;
    } status_t;

endpackage

// ===== hdl/cbrb_ifs.sv =====
// Channel interfaces of the cell buffer: request, response and configuration.
// Depends on cbrb_pkg for the payload widths.
interface cbrb_req_if;
    import cbrb_pkg::*;
    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    operation;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic [COORD_W-1:0] rect_width;
    logic [COORD_W-1:0] rect_height;
    logic [COLOR_W-1:0] color;
    logic [GLYPH_W-1:0] glyph;

    modport source (output valid, operation, pos_x, pos_y, rect_width, rect_height,
                    color, glyph, input ready);
    modport sink (input valid, operation, pos_x, pos_y, rect_width, rect_height,
                  color, glyph, output ready);
endinterface

interface cbrb_rsp_if;
    import cbrb_pkg::*;
    logic               valid;
    logic               ready;
    logic [GLYPH_W-1:0] glyph_out;
    logic [COLOR_W-1:0] foreground_out;
    logic [COLOR_W-1:0] background_out;
    logic               out_of_range;

    modport source (output valid, glyph_out, foreground_out, background_out,
                    out_of_range, input ready);
    modport sink (input valid, glyph_out, foreground_out, background_out,
                  out_of_range, output ready);
endinterface

interface cbrb_cfg_if;
    import cbrb_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/cbrb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cbrb_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/cbrb_queue.sv =====
// Short command queue between the front and back ends of the cell buffer.
// Depends on cbrb_pkg for cmd_t and the queue depth.
module cbrb_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  cbrb_pkg::cmd_t push_cmd,
    output logic           pop_valid,
    input  logic           pop_ready,
    output cbrb_pkg::cmd_t pop_cmd
);
    import cbrb_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed beat
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== hdl/cbrb_front.sv =====
// Front end of the cell buffer: configuration registers, cell limit,
// request acceptance, classification and start index. Depends on cbrb_pkg.
module cbrb_front #(
    parameter int CELL_CAPACITY = cbrb_pkg::CELL_CAPACITY_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    cbrb_cfg_if.sink          cfg,
    cbrb_req_if.sink          req,
    input  cbrb_pkg::status_t status,
    output logic              push_valid,
    input  logic              push_ready,
    output cbrb_pkg::cmd_t    push_cmd,
    output cbrb_pkg::grid_t   grid
);
    import cbrb_pkg::*;

    logic [CFG_W-1:0] width_reg, width_next;
    logic [CFG_W-1:0] height_reg, height_next;
    logic [IDX_W-1:0] limit_reg, limit_next;
    logic [IDX_W-1:0] area;
    logic             keep;

    // Take register writes in every cycle
    assign cfg.ready = 1'b1;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                REG_WIDTH:  width_next  = cfg.data;
                REG_HEIGHT: height_next = cfg.data;
                default:    ;
            endcase
        end
    end

    // Saturate the grid area at the store size
    assign area       = IDX_W'(width_reg) * IDX_W'(height_reg);
    assign limit_next = (area < IDX_W'(CELL_CAPACITY)) ? area : IDX_W'(CELL_CAPACITY);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            limit_reg  <= '0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            limit_reg  <= limit_next;
        end
    end

    assign grid.stride = width_reg;
    assign grid.limit  = limit_reg;

    // Drop unused codes and empty rectangles; queue the rest
    always_comb
    begin
        case (req.operation)
            OP_DRAW: keep = (req.rect_width != '0) && (req.rect_height != '0);
            OP_PUT:  keep = 1'b1;
            OP_READ: keep = 1'b1;
            default: keep = 1'b0;
        endcase
    end

    assign req.ready  = status.accepting && push_ready;
    assign push_valid = req.valid && status.accepting && keep;

    // Start index of the item: pos_y * stride + pos_x
    assign push_cmd.op     = req.operation;
    assign push_cmd.base   = IDX_W'(req.pos_y) * IDX_W'(width_reg) + IDX_W'(req.pos_x);
    assign push_cmd.rect_w = req.rect_width;
    assign push_cmd.rect_h = req.rect_height;
    assign push_cmd.color  = req.color;
    assign push_cmd.glyph  = req.glyph;

endmodule

// ===== hdl/cbrb_back.sv =====
// Back end of the cell buffer: clearing pass, rectangle walk with blend,
// glyph put, cell read and the response register. Depends on cbrb_pkg, cbrb_ram.
module cbrb_back #(
    parameter int CELL_CAPACITY = cbrb_pkg::CELL_CAPACITY_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  cbrb_pkg::cmd_t    cmd,
    input  cbrb_pkg::grid_t   grid,
    output cbrb_pkg::status_t status,
    cbrb_rsp_if.source        rsp
);
    import cbrb_pkg::*;

    localparam int AW    = $clog2(CELL_CAPACITY);
    localparam int SUM_W = 2 * CHAN_W;
    localparam int NCH   = 3;

    typedef enum logic [6:0] {
        ST_CLEAR    = 7'b0000001,
        ST_IDLE     = 7'b0000010,
        ST_READ     = 7'b0000100,
        ST_READ_CAP = 7'b0001000,
        ST_CELL     = 7'b0010000,
        ST_MUL      = 7'b0100000,
        ST_DIV      = 7'b1000000
    } state_t;

    // Exact floor(s / 255) for s up to 255 * 255
    function automatic logic [CHAN_W-1:0] div255(input logic [SUM_W-1:0] s);
        logic [SUM_W:0] t;
        t = {1'b0, s} + (SUM_W+1)'(1) + (SUM_W+1)'(s[SUM_W-1:CHAN_W]);
        return t[SUM_W-1:CHAN_W];
    endfunction

    state_t             state_reg, state_next;
    logic [AW-1:0]      clr_reg, clr_next;
    cmd_t               cmd_reg, cmd_next;
    logic [IDX_W-1:0]   row_reg, row_next;
    logic [IDX_W-1:0]   cell_reg, cell_next;
    logic [COORD_W-1:0] col_reg, col_next;
    logic [COORD_W-1:0] line_reg, line_next;
    logic [SUM_W-1:0]   sum_fg_reg [NCH];
    logic [SUM_W-1:0]   sum_fg_next [NCH];
    logic [SUM_W-1:0]   sum_bg_reg [NCH];
    logic [SUM_W-1:0]   sum_bg_next [NCH];
    logic               out_valid_reg, out_valid_next;
    logic [GLYPH_W-1:0] glyph_out_reg, glyph_out_next;
    logic [COLOR_W-1:0] fg_out_reg, fg_out_next;
    logic [COLOR_W-1:0] bg_out_reg, bg_out_next;
    logic               oor_reg, oor_next;

    logic               we_glyph, we_fg, we_bg;
    logic [AW-1:0]      waddr;
    logic [GLYPH_W-1:0] wglyph, rd_glyph;
    logic [COLOR_W-1:0] wfg, rd_fg;
    logic [COLOR_W-1:0] wbg, rd_bg;

    logic               in_lim, row_end, last_line, advance;
    logic [IDX_W-1:0]   row_step;
    logic [CHAN_W-1:0]  alpha, alpha_inv;
    logic [COLOR_W-1:0] mix_fg, mix_bg;

    // Cell store: one RAM per field, read address follows the walk
    cbrb_ram #(.WIDTH(GLYPH_W), .DEPTH(CELL_CAPACITY)) u_glyph_ram (
        .clk(clk), .we(we_glyph), .waddr(waddr), .wdata(wglyph),
        .raddr(cell_reg[AW-1:0]), .rdata(rd_glyph)
    );
    cbrb_ram #(.WIDTH(COLOR_W), .DEPTH(CELL_CAPACITY)) u_fg_ram (
        .clk(clk), .we(we_fg), .waddr(waddr), .wdata(wfg),
        .raddr(cell_reg[AW-1:0]), .rdata(rd_fg)
    );
    cbrb_ram #(.WIDTH(COLOR_W), .DEPTH(CELL_CAPACITY)) u_bg_ram (
        .clk(clk), .we(we_bg), .waddr(waddr), .wdata(wbg),
        .raddr(cell_reg[AW-1:0]), .rdata(rd_bg)
    );

    // Walk bookkeeping
    assign in_lim    = (cell_reg < grid.limit);
    assign row_end   = !in_lim || (col_reg == cmd_reg.rect_w - 1'b1);
    assign last_line = (line_reg == cmd_reg.rect_h - 1'b1);
    assign row_step  = row_reg + IDX_W'(grid.stride);

    // Blend products per channel, then the divide and word assembly
    assign alpha     = cmd_reg.color[CHAN_W-1:0];
    assign alpha_inv = ALPHA_OPAQUE - alpha;

    always_comb
    begin
        for (int c = 0; c < NCH; c++)
        begin
            sum_fg_next[c] = SUM_W'(cmd_reg.color[COLOR_W-1-CHAN_W*c -: CHAN_W]) * SUM_W'(alpha)
                           + SUM_W'(rd_fg[COLOR_W-1-CHAN_W*c -: CHAN_W]) * SUM_W'(alpha_inv);
            sum_bg_next[c] = SUM_W'(cmd_reg.color[COLOR_W-1-CHAN_W*c -: CHAN_W]) * SUM_W'(alpha)
                           + SUM_W'(rd_bg[COLOR_W-1-CHAN_W*c -: CHAN_W]) * SUM_W'(alpha_inv);
        end
    end

    assign mix_fg = {div255(sum_fg_reg[0]), div255(sum_fg_reg[1]), div255(sum_fg_reg[2]),
                     ALPHA_OPAQUE};
    assign mix_bg = {div255(sum_bg_reg[0]), div255(sum_bg_reg[1]), div255(sum_bg_reg[2]),
                     ALPHA_OPAQUE};

    assign status.accepting = (state_reg != ST_CLEAR);
    assign status.busy      = (state_reg != ST_IDLE);

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        cmd_next       = cmd_reg;
        row_next       = row_reg;
        cell_next      = cell_reg;
        col_next       = col_reg;
        line_next      = line_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        glyph_out_next = glyph_out_reg;
        fg_out_next    = fg_out_reg;
        bg_out_next    = bg_out_reg;
        oor_next       = oor_reg;
        we_glyph       = 1'b0;
        we_fg          = 1'b0;
        we_bg          = 1'b0;
        waddr          = cell_reg[AW-1:0];
        wglyph         = '0;
        wfg            = '0;
        wbg            = '0;
        cmd_ready      = 1'b0;
        advance        = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                // Zero one entry of every store per cycle
                we_glyph = 1'b1;
                we_fg    = 1'b1;
                we_bg    = 1'b1;
                waddr    = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == AW'(CELL_CAPACITY - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    cmd_next  = cmd;
                    row_next  = cmd.base;
                    cell_next = cmd.base;
                    col_next  = '0;
                    line_next = '0;
                    case (cmd.op)
                        OP_DRAW: state_next = ST_CELL;
                        OP_PUT:
                        begin
                            // Write glyph and foreground in place
                            if (cmd.base < grid.limit)
                            begin
                                we_glyph = 1'b1;
                                we_fg    = 1'b1;
                                waddr    = cmd.base[AW-1:0];
                                wglyph   = cmd.glyph;
                                wfg      = cmd.color;
                            end
                        end
                        OP_READ: state_next = ST_READ;
                        default: ;
                    endcase
                end
            end
            ST_READ:
            begin
                // Wait for a free response register
                if (!out_valid_reg)
                begin
                    if (in_lim)
                    begin
                        state_next = ST_READ_CAP;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        glyph_out_next = '0;
                        fg_out_next    = '0;
                        bg_out_next    = '0;
                        oor_next       = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
            end
            ST_READ_CAP:
            begin
                out_valid_next = 1'b1;
                glyph_out_next = rd_glyph;
                fg_out_next    = rd_fg;
                bg_out_next    = rd_bg;
                oor_next       = 1'b0;
                state_next     = ST_IDLE;
            end
            ST_CELL:
            begin
                if (!in_lim)
                begin
                    advance = 1'b1;
                end
                else if (alpha == ALPHA_OPAQUE)
                begin
                    we_glyph = 1'b1;
                    we_bg    = 1'b1;
                    wglyph   = SPACE_GLYPH;
                    wbg      = cmd_reg.color;
                    advance  = 1'b1;
                end
                else
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                we_fg   = 1'b1;
                we_bg   = 1'b1;
                wfg     = mix_fg;
                wbg     = mix_bg;
                advance = 1'b1;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Step to the next cell, the next row, or finish
        if (advance)
        begin
            if (!row_end)
            begin
                cell_next  = cell_reg + 1'b1;
                col_next   = col_reg + 1'b1;
                state_next = ST_CELL;
            end
            else if (!last_line)
            begin
                row_next   = row_step;
                cell_next  = row_step;
                col_next   = '0;
                line_next  = line_reg + 1'b1;
                state_next = ST_CELL;
            end
            else
            begin
                state_next = ST_IDLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        row_reg       <= row_next;
        cell_reg      <= cell_next;
        col_reg       <= col_next;
        line_reg      <= line_next;
        glyph_out_reg <= glyph_out_next;
        fg_out_reg    <= fg_out_next;
        bg_out_reg    <= bg_out_next;
        oor_reg       <= oor_next;
        for (int c = 0; c < NCH; c++)
        begin
            sum_fg_reg[c] <= sum_fg_next[c];
            sum_bg_reg[c] <= sum_bg_next[c];
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.glyph_out      = glyph_out_reg;
    assign rsp.foreground_out = fg_out_reg;
    assign rsp.background_out = bg_out_reg;
    assign rsp.out_of_range   = oor_reg;

endmodule

// ===== hdl/cell_buffer_rect_blend.sv =====
// Put: stored as the back end takes it. Read: ST_READ, ST_READ_CAP, then the
// response register. Draw: opaque cell written in ST_CELL; translucent cell via
// ST_CELL (read), ST_MUL (multiply), ST_DIV (divide and write on the store port).
// Throughput is set by the back-end sequencer; a 2-entry queue decouples it.
// Reset: registers return to 80 x 25; a clearing pass zeroes the store with
// req.ready low, configuration beats still taken.
module cell_buffer_rect_blend #(
    parameter int CELL_CAPACITY = cbrb_pkg::CELL_CAPACITY_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    cbrb_cfg_if.sink   cfg,
    cbrb_req_if.sink   req,
    cbrb_rsp_if.source rsp
);
    import cbrb_pkg::*;

    logic    push_valid, push_ready;
    cmd_t    push_cmd;
    logic    pop_valid, pop_ready;
    cmd_t    pop_cmd;
    grid_t   grid;
    status_t status;

    // Accept and classify
    cbrb_front #(.CELL_CAPACITY(CELL_CAPACITY)) u_front (
        .clk(clk), .rst_n(rst_n), .cfg(cfg), .req(req), .status(status),
        .push_valid(push_valid), .push_ready(push_ready), .push_cmd(push_cmd),
        .grid(grid)
    );

    // Decouple front from back
    cbrb_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .push_valid(push_valid), .push_ready(push_ready), .push_cmd(push_cmd),
        .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_cmd(pop_cmd)
    );

    // Carry out commands on the store
    cbrb_back #(.CELL_CAPACITY(CELL_CAPACITY)) u_back (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(pop_valid), .cmd_ready(pop_ready), .cmd(pop_cmd),
        .grid(grid), .status(status), .rsp(rsp)
    );

endmodule

// ===== hdl/cbrb_checker.sv =====
// Port-level checks for the cell buffer, bound to the top level.
// Depends on cbrb_pkg and cell_buffer_rect_blend.
module cbrb_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         req_ready,
    input logic                         rsp_valid,
    input logic                         rsp_ready,
    input logic [cbrb_pkg::GLYPH_W-1:0] glyph_out,
    input logic [cbrb_pkg::COLOR_W-1:0] foreground_out,
    input logic [cbrb_pkg::COLOR_W-1:0] background_out,
    input logic                         out_of_range
);
    import cbrb_pkg::*;

    // Clearing pass holds off requests and responses right after reset
    a_clear_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $past(!rst_n) |-> (!req_ready && !rsp_valid))
        else $error("request or response open during clearing pass");

    // Out-of-range read carries zero payload
    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && out_of_range) |->
        (glyph_out == '0 && foreground_out == '0 && background_out == '0))
        else $error("out-of-range response with nonzero fields");

    // Hold a stalled response beat
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> rsp_valid)
        else $error("response dropped while stalled");

    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=>
        ($stable(glyph_out) && $stable(foreground_out) && $stable(background_out)
         && $stable(out_of_range)))
        else $error("response payload changed while stalled");

endmodule

bind cell_buffer_rect_blend cbrb_checker u_cbrb_checker (
    .clk(clk),
    .rst_n(rst_n),
    .req_ready(req.ready),
    .rsp_valid(rsp.valid),
    .rsp_ready(rsp.ready),
    .glyph_out(rsp.glyph_out),
    .foreground_out(rsp.foreground_out),
    .background_out(rsp.background_out),
    .out_of_range(rsp.out_of_range)
);

// ===== sim/cell_buffer_rect_blend_tb.sv =====
// Self-checking bench for cell_buffer_rect_blend: directed and random draw, put and read
// beats update a shadow cell store; read beats are checked against it or a scripted value.
// Depends on cbrb_pkg, the cbrb channel interfaces and the cell_buffer_rect_blend RTL.
module cell_buffer_rect_blend_tb;
    import cbrb_pkg::*;

    localparam int CELLS         = CELL_CAPACITY_DEFAULT;
    localparam int MAX_GAP       = 13;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 16;
    localparam int STALL_LIMIT   = 400000;
    localparam int BURST_READS   = 16;
    localparam int SIDE_SEND     = 0;
    localparam int SIDE_DRAIN    = 1;

    localparam logic [OP_W-1:0]      OP_UNUSED       = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] w;
        logic [COORD_W-1:0] h;
        logic [COLOR_W-1:0] color;
        logic [GLYPH_W-1:0] glyph;
    } cell_cmd_t;

    typedef struct packed {
        logic [GLYPH_W-1:0] glyph;
        logic [COLOR_W-1:0] fg;
        logic [COLOR_W-1:0] bg;
        logic               oor;
    } cell_view_t;

    typedef struct packed {
        cell_cmd_t  cmd;
        logic       typed;
        cell_view_t view;
    } script_row_t;

    typedef struct packed {
        logic [CFG_W-1:0] cols;
        logic [CFG_W-1:0] rows;
        logic [15:0]      items;
    } grid_phase_t;

    localparam cell_view_t BLANK_CELL = '0;
    localparam cell_view_t OOR_CELL   = '{21'h0, 32'h0, 32'h0, 1'b1};

    // Directed rows run on the reset grid of 80 x 25 (limit 2000)
    localparam script_row_t SCRIPT [26] = '{
        '{'{OP_READ, 8'd0, 8'd0, 8'd0, 8'd0, 32'h0, 21'h0}, 1'b1, BLANK_CELL},
        '{'{OP_READ, 8'd79, 8'd24, 8'd0, 8'd0, 32'h0, 21'h0}, 1'b1, BLANK_CELL},
        '{'{OP_READ, 8'd0, 8'd25, 8'd0, 8'd0, 32'h0, 21'h0}, 1'b1, OOR_CELL},
        '{'{OP_READ, 8'd255, 8'd255, 8'd0, 8'd0, 32'h0, 21'h0}, 1'b1, OOR_CELL},
        '{'{OP_PUT, 8'd3, 8'd2, 8'd0, 8'd0, 32'hFFFF_FFFF, 21'h1F_FFFF}, 1'b0, BLANK_CELL},
        '{'{OP_READ, 8'd3, 8'd2, 8'd0, 8'd0, 32'h0, 21'h0}, 1'b1,
          '{21'h1F_FFFF, 32'hFFFF_FFFF, 32'h0, 1'b0}},
        '{'{OP_DRAW, 8'd0, 8'd0, 8'd1, 8'd1, 32'hA5C3_5AFF, 21'h0}, 1'b0, BLANK_CELL},
        '{'{OP_READ, 8'd0, 8'd0, 8'd0, 8'd0, 32'h0, 21'h0}, 1'b1,
          '{SPACE_GLYPH, 32'h0, 32'hA5C3_5AFF, 1'b0}},
        // fully transparent and half transparent blends
        '{'{OP_DRAW, 8'd0, 8'd0, 8'd1, 8'd1, 32'hFFFF_FF00, 21'h0}, 1'b0, BLANK_CELL},
        '{'{OP_READ, 8'd0, 8'd0, 8'd0, 8'd0, 32'h0, 21'h0}, 1'b0, BLANK_CELL},
        '{'{OP_DRAW, 8'd3, 8'd2, 8'd1, 8'd1, 32'hFF00_FF80, 21'h0}, 1'b0, BLANK_CELL},
        '{'{OP_READ, 8'd3, 8'd2, 8'd0, 8'd0, 32'h0, 21'h0}, 1'b0, BLANK_CELL},
        // empty rectangles leave the cell untouched
        '{'{OP_DRAW, 8'd10, 8'd10, 8'd0, 8'd5, 32'h0000_00FF, 21'h0}, 1'b0, BLANK_CELL},
        '{'{OP_DRAW, 8'd10, 8'd10, 8'd5, 8'd0, 32'h0000_00FF, 21'h0}, 1'b0, BLANK_CELL},
        '{'{OP_READ, 8'd10, 8'd10, 8'd0, 8'd0, 32'h0, 21'h0}, 1'b1, BLANK_CELL},
        // unused operation code changes nothing
        '{'{OP_UNUSED, 8'd5, 8'd5, 8'd3, 8'd3, 32'h1234_56FF, 21'h1234}, 1'b0, BLANK_CELL},
        '{'{OP_READ, 8'd5, 8'd5, 8'd0, 8'd0, 32'h0, 21'h0}, 1'b1, BLANK_CELL},
        // put just past the limit, then a draw that wraps into the next row
        '{'{OP_PUT, 8'd0, 8'd25, 8'd0, 8'd0, 32'h5555_AAAA, 21'h7}, 1'b0, BLANK_CELL},
        '{'{OP_DRAW, 8'd78, 8'd0, 8'd4, 8'd1, 32'h3366_99FF, 21'h0}, 1'b0, BLANK_CELL},
        '{'{OP_READ, 8'd1, 8'd1, 8'd0, 8'd0, 32'h0, 21'h0}, 1'b0, BLANK_CELL},
        // rectangle running over the cell limit
        '{'{OP_DRAW, 8'd70, 8'd24, 8'd20, 8'd3, 32'h00FF_0040, 21'h0}, 1'b0, BLANK_CELL},
        '{'{OP_READ, 8'd79, 8'd24, 8'd0, 8'd0, 32'h0, 21'h0}, 1'b0, BLANK_CELL},
        // largest rectangles: one translucent from the origin, one wholly out of range
        '{'{OP_DRAW, 8'd0, 8'd0, 8'd255, 8'd255, 32'h8040_20C0, 21'h0}, 1'b0, BLANK_CELL},
        '{'{OP_DRAW, 8'd255, 8'd255, 8'd255, 8'd255, 32'hFFFF_FFFF, 21'h0}, 1'b0,
          BLANK_CELL},
        '{'{OP_READ, 8'd40, 8'd12, 8'd0, 8'd0, 32'h0, 21'h0}, 1'b0, BLANK_CELL},
        '{'{OP_READ, 8'd3, 8'd2, 8'd0, 8'd0, 32'h0, 21'h0}, 1'b0, BLANK_CELL}
    };

    // Grid settings walked by the random part
    localparam grid_phase_t PHASES [10] = '{
        '{9'd16, 9'd16, 16'd150},   // small grid, heavy overdraw
        '{9'd64, 9'd64, 16'd150},   // grid exactly fills the store
        '{9'd256, 9'd256, 16'd150}, // widest legal grid, limit saturates
        '{9'd1, 9'd256, 16'd150},   // one column
        '{9'd256, 9'd1, 16'd150},   // one row
        '{9'd511, 9'd511, 16'd150}, // past the legal range, every register bit set
        '{9'd0, 9'd25, 16'd40},     // zero width: nothing in range
        '{9'd80, 9'd0, 16'd40},     // zero height: nothing in range
        '{9'd7, 9'd9, 16'd150},
        '{9'd100, 9'd50, 16'd150}
    };

    logic clk;
    logic rst_n;

    cbrb_req_if req_ch ();
    cbrb_rsp_if rsp_ch ();
    cbrb_cfg_if cfg_ch ();

    cell_buffer_rect_blend #(
        .CELL_CAPACITY (CELLS)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Shadow cell store and grid registers
    logic [GLYPH_W-1:0] shadow_glyph [CELLS];
    logic [COLOR_W-1:0] shadow_fg [CELLS];
    logic [COLOR_W-1:0] shadow_bg [CELLS];
    int unsigned        grid_w;
    int unsigned        grid_h;

    cell_view_t         pending_reads [$];
    logic [COORD_W-1:0] last_x;
    logic [COORD_W-1:0] last_y;
    bit                 hold_request;
    bit                 calm_run [2];
    int                 run_left [2];
    int                 mismatches;
    int                 reads_checked;
    int                 commands_sent;
    int                 reg_writes;
    int                 holds_done;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic longint cell_limit();
        longint n;
        n = longint'(grid_w) * grid_h;
        return (n < CELLS) ? n : CELLS;
    endfunction

    function automatic logic [CHAN_W-1:0] blend_channel(input logic [CHAN_W-1:0] src,
                                                        input logic [CHAN_W-1:0] dst,
                                                        input logic [CHAN_W-1:0] alpha);
        int unsigned s;
        int unsigned d;
        int unsigned a;
        s = src;
        d = dst;
        a = alpha;
        return CHAN_W'((s * a + d * (255 - a)) / 255);
    endfunction

    function automatic logic [COLOR_W-1:0] blend_word(input logic [COLOR_W-1:0] color,
                                                      input logic [COLOR_W-1:0] old);
        return {blend_channel(color[31:24], old[31:24], color[7:0]),
                blend_channel(color[23:16], old[23:16], color[7:0]),
                blend_channel(color[15:8], old[15:8], color[7:0]),
                ALPHA_OPAQUE};
    endfunction

    // Advance the shadow store by one command; return 1 when it yields a read beat
    function automatic bit apply_command(input cell_cmd_t c, output cell_view_t view);
        longint lim;
        longint idx;
        int     i;
        int     j;
        lim  = cell_limit();
        view = BLANK_CELL;
        case (c.op)
            OP_DRAW:
            begin
                for (i = 0; i < c.h; i++)
                begin
                    for (j = 0; j < c.w; j++)
                    begin
                        idx = (longint'(c.y) + i) * grid_w + c.x + j;
                        if (idx >= lim)
                            break;
                        if (c.color[7:0] == ALPHA_OPAQUE)
                        begin
                            shadow_glyph[idx] = SPACE_GLYPH;
                            shadow_bg[idx]    = c.color;
                        end
                        else
                        begin
                            shadow_fg[idx] = blend_word(c.color, shadow_fg[idx]);
                            shadow_bg[idx] = blend_word(c.color, shadow_bg[idx]);
                        end
                    end
                end
            end
            OP_PUT:
            begin
                idx = longint'(c.y) * grid_w + c.x;
                if (idx < lim)
                begin
                    shadow_glyph[idx] = c.glyph;
                    shadow_fg[idx]    = c.color;
                end
            end
            OP_READ:
            begin
                idx = longint'(c.y) * grid_w + c.x;
                if (idx < lim)
                    view = '{shadow_glyph[idx], shadow_fg[idx], shadow_bg[idx], 1'b0};
                else
                    view = OOR_CELL;
            end
            default: ;
        endcase
        return c.op == OP_READ;
    endfunction

    // Per-side wait before a beat, with runs of back-to-back beats mixed in
    function automatic int pick_gap(input int side);
        if (run_left[side] == 0)
        begin
            calm_run[side] = ($urandom_range(0, 3) == 0);
            run_left[side] = $urandom_range(16, 64);
        end
        run_left[side]--;
        return calm_run[side] ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    function automatic cell_cmd_t make_random_command();
        cell_cmd_t   c;
        int unsigned roll;
        int unsigned rows_on;
        int unsigned x_top;
        int unsigned y_top;
        longint      lim;
        lim  = cell_limit();
        roll = $urandom_range(0, 99);
        if (roll < 35)
            c.op = OP_DRAW;
        else if (roll < 65)
            c.op = OP_PUT;
        else if (roll < 95)
            c.op = OP_READ;
        else
            c.op = OP_UNUSED;
        c.color = $urandom;
        c.glyph = $urandom_range(0, (1 << GLYPH_W) - 1);
        // lean on the two ends of the blend: opaque and fully transparent
        roll = $urandom_range(0, 5);
        if (roll < 2)
            c.color[7:0] = ALPHA_OPAQUE;
        else if (roll == 2)
            c.color[7:0] = '0;
        // place mostly in the live part of the grid, often next to the last write
        if (grid_w == 0 || lim == 0 || $urandom_range(0, 7) == 0)
        begin
            c.x = $urandom;
            c.y = $urandom;
        end
        else if (c.op != OP_DRAW && $urandom_range(0, 1) == 0)
        begin
            c.x = last_x + $urandom_range(0, 2);
            c.y = last_y + $urandom_range(0, 1);
        end
        else
        begin
            rows_on = (lim + grid_w - 1) / grid_w;
            x_top   = (grid_w > 256) ? 255 : grid_w - 1;
            y_top   = (rows_on > 256) ? 255 : rows_on - 1;
            c.x     = $urandom_range(0, x_top);
            c.y     = $urandom_range(0, y_top);
        end
        // keep rectangles small; full-range sizes only where rows are long
        roll = $urandom_range(0, 99);
        if (roll < 2 && grid_w >= 16)
        begin
            c.w = $urandom;
            c.h = $urandom;
        end
        else if (roll < 12)
        begin
            c.w = $urandom_range(0, 24);
            c.h = $urandom_range(0, 24);
        end
        else
        begin
            c.w = $urandom_range(0, 6);
            c.h = $urandom_range(0, 6);
        end
        if (c.op == OP_DRAW || c.op == OP_PUT)
        begin
            last_x = c.x;
            last_y = c.y;
        end
        return c;
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("MISMATCH at read beat %0d: %s", reads_checked, what);
    endtask

    // Offer one command beat; entered and left at a falling edge
    task automatic send_command(input cell_cmd_t c, input int gap, input logic typed,
                                input cell_view_t hand_view);
        cell_view_t predicted;
        if (gap != 0)
        begin
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.operation   = c.op;
        req_ch.pos_x       = c.x;
        req_ch.pos_y       = c.y;
        req_ch.rect_width  = c.w;
        req_ch.rect_height = c.h;
        req_ch.color       = c.color;
        req_ch.glyph       = c.glyph;
        req_ch.valid       = 1'b1;
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
            @(posedge clk);
        // advance the shadow store in acceptance order
        if (apply_command(c, predicted))
            pending_reads.push_back(typed ? hand_view : predicted);
        if (c.op != OP_UNUSED)
            commands_sent++;
        @(negedge clk);
    endtask

    // Fence with a read, wait for every read beat, then let the block go quiet
    task automatic quiesce();
        cell_cmd_t fence;
        fence    = '0;
        fence.op = OP_READ;
        send_command(fence, 0, 1'b0, BLANK_CELL);
        req_ch.valid = 1'b0;
        while (pending_reads.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_W-1:0] value);
        cfg_ch.index = index;
        cfg_ch.data  = value;
        cfg_ch.valid = 1'b1;
        @(posedge clk);
        while (cfg_ch.ready !== 1'b1)
            @(posedge clk);
        if (index == REG_WIDTH)
            grid_w = value;
        else if (index == REG_HEIGHT)
            grid_h = value;
        reg_writes++;
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    // Response side: random stalls, one long hold on request, check each beat
    initial
    begin : drain
        int         stall;
        cell_view_t got;
        cell_view_t want;
        rsp_ch.ready = 1'b0;
        forever
        begin
            stall = pick_gap(SIDE_DRAIN);
            if (hold_request)
            begin
                stall        = HOLD_CYCLES;
                hold_request = 1'b0;
                holds_done++;
            end
            @(negedge clk);
            if (stall != 0)
            begin
                rsp_ch.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp_ch.ready = 1'b1;
            @(posedge clk);
            while (rsp_ch.valid !== 1'b1)
                @(posedge clk);
            got = '{rsp_ch.glyph_out, rsp_ch.foreground_out, rsp_ch.background_out,
                    rsp_ch.out_of_range};
            if (pending_reads.size() == 0)
                report_mismatch("read beat with no read outstanding");
            else
            begin
                want = pending_reads.pop_front();
                if (got.glyph !== want.glyph)
                    report_mismatch($sformatf("glyph_out %h, expected %h", got.glyph,
                                              want.glyph));
                if (got.fg !== want.fg)
                    report_mismatch($sformatf("foreground_out %h, expected %h", got.fg,
                                              want.fg));
                if (got.bg !== want.bg)
                    report_mismatch($sformatf("background_out %h, expected %h", got.bg,
                                              want.bg));
                if (got.oor !== want.oor)
                    report_mismatch($sformatf("out_of_range %b, expected %b", got.oor,
                                              want.oor));
                reads_checked++;
            end
        end
    end

    // Stop the run after a long stretch with no beat on any channel
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: %0d cycles with no beat, %0d reads outstanding", quiet,
                 pending_reads.size());
        $display("cell_buffer_rect_blend_tb failed");
        $finish;
    end

    initial
    begin : stimulus
        cell_cmd_t c;
        int        sent;
        req_ch.valid       = 1'b0;
        req_ch.operation   = OP_DRAW;
        req_ch.pos_x       = '0;
        req_ch.pos_y       = '0;
        req_ch.rect_width  = '0;
        req_ch.rect_height = '0;
        req_ch.color       = '0;
        req_ch.glyph       = '0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = REG_WIDTH;
        cfg_ch.data        = '0;
        hold_request       = 1'b0;
        last_x             = '0;
        last_y             = '0;
        rst_n              = 1'b0;

        // reset the shadow store to match the cleared block
        foreach (shadow_glyph[k])
        begin
            shadow_glyph[k] = '0;
            shadow_fg[k]    = '0;
            shadow_bg[k]    = '0;
        end
        grid_w = WIDTH_RESET;
        grid_h = HEIGHT_RESET;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed rows on the reset grid
        foreach (SCRIPT[k])
            send_command(SCRIPT[k].cmd, pick_gap(SIDE_SEND), SCRIPT[k].typed, SCRIPT[k].view);

        // random commands under each grid setting
        for (int p = 0; p < $size(PHASES); p++)
        begin
            quiesce();
            write_reg(REG_WIDTH, PHASES[p].cols);
            write_reg(REG_HEIGHT, PHASES[p].rows);
            write_reg(p[0] ? REG_UNMAPPED_HI : REG_UNMAPPED_LO, $urandom_range(0, 511));
            // hold the response side while a burst of reads backs up the input
            if (p == 0 || p == 5)
            begin
                hold_request = 1'b1;
                repeat (BURST_READS)
                begin
                    c    = make_random_command();
                    c.op = OP_READ;
                    send_command(c, 0, 1'b0, BLANK_CELL);
                end
            end
            sent = 0;
            while (sent < PHASES[p].items)
            begin
                c = make_random_command();
                send_command(c, pick_gap(SIDE_SEND), 1'b0, BLANK_CELL);
                if (c.op != OP_UNUSED)
                    sent++;
            end
        end
        req_ch.valid = 1'b0;

        // drain outstanding reads, then let any trailing draw finish
        while (pending_reads.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d commands over the reset grid and %0d grid settings, %0d reg writes",
                 commands_sent, $size(PHASES), reg_writes);
        $display("checked %0d read beats with %0d long response holds, %0d mismatches",
                 reads_checked, holds_done, mismatches);
        if (mismatches == 0)
            $display("cell_buffer_rect_blend_tb passed");
        else
            $display("cell_buffer_rect_blend_tb failed");
        $finish;
    end

endmodule

// ===== cell_buffer_rect_blend.f =====
hdl/cbrb_pkg.sv
hdl/cbrb_ifs.sv
hdl/cbrb_ram.sv
hdl/cbrb_queue.sv
hdl/cbrb_front.sv
hdl/cbrb_back.sv
hdl/cell_buffer_rect_blend.sv
hdl/cbrb_checker.sv
sim/cell_buffer_rect_blend_tb.sv
